[rtl/cmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cmt_pkg;

    // Q30 value of pi.
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    // Slice request passed from the front end to the back end.
    typedef struct packed {
        logic [8:0] index;
        logic       emit_rim;
        logic       emit_tris;
        logic       emit_caps;
    } slice_req_t;

    // One result record.
    typedef struct packed {
        logic        kind;
        logic [9:0]  vnum;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [9:0]  ca;
        logic [9:0]  cb;
        logic [9:0]  cc;
        logic        last;
    } record_t;

    // Signed 33-bit sum saturated to 32 bits.
    function automatic logic [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -33'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

[rtl/cylinder_mesh_tessellator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Capped cylinder tessellator.
// A request is a slice index on division_index, taken at a clock edge with
// start high and busy low. Each request yields up to eight records (cap
// centers for index 0, two rim vertices, side and fan triangles), each shown
// for one cycle with strobe high; last_record marks the final one. An index
// above the division count yields nothing.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// the user must write only while idle; the block itself does not enforce it.
// The first rim record follows the bit-serial phase division and the seven
// Horner steps of the shared multiplier in the cosine unit. A two-entry
// queue between the front and back ends keeps start open while a slice is
// in work.
// The receiver cannot stall; records are never held.
// Reset clears the queue and sequencers and loads the register defaults.
module cylinder_mesh_tessellator #(
    parameter int MAX_DIVISIONS = 256,
    parameter int PHASE_BITS    = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [8:0]  division_index,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             strobe,
    output logic             record_kind,
    output logic [9:0]       vertex_number,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [31:0]      pos_z,
    output logic [9:0]       corner_a,
    output logic [9:0]       corner_b,
    output logic [9:0]       corner_c,
    output logic             last_record
);
    localparam logic [2:0] R_CX = 3'd0, R_CY = 3'd1, R_CZ = 3'd2, R_RAD = 3'd3,
        R_HGT = 3'd4, R_TOP = 3'd5, R_BOT = 3'd6, R_DIV = 3'd7;
    localparam int MAXD = (MAX_DIVISIONS > 256) ? 256 : MAX_DIVISIONS;

    logic [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] rad_reg, hgt_reg;
    logic top_reg, bot_reg;
    logic [8:0] div_reg, dcount;
    cmt_pkg::slice_req_t req;
    logic req_valid, req_take;
    cmt_pkg::record_t rec;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            rad_reg <= 31'd32768; hgt_reg <= 31'd65536;
            top_reg <= 1'b1; bot_reg <= 1'b1; div_reg <= 9'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                R_CX:  cx_reg  <= cfg_data;
                R_CY:  cy_reg  <= cfg_data;
                R_CZ:  cz_reg  <= cfg_data;
                R_RAD: rad_reg <= cfg_data[30:0];
                R_HGT: hgt_reg <= cfg_data[30:0];
                R_TOP: top_reg <= cfg_data[0];
                R_BOT: bot_reg <= cfg_data[0];
                R_DIV: div_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Division count limited to its legal range.
    assign dcount = (div_reg == 9'd0) ? 9'd1
                  : ({23'd0, div_reg} > MAXD) ? 9'(MAXD) : div_reg;

    cmt_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .division_index(division_index), .div_count(dcount),
        .req(req), .req_valid(req_valid), .req_take(req_take)
    );

    cmt_back #(.PHASE_BITS(PHASE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_take(req_take), .div_count(dcount), .cx(cx_reg), .cy(cy_reg),
        .cz(cz_reg), .rad(rad_reg), .hgt(hgt_reg), .top_on(top_reg),
        .bot_on(bot_reg), .strobe(strobe), .rec(rec)
    );

    assign record_kind   = rec.kind;
    assign vertex_number = rec.vnum;
    assign pos_x         = rec.px;
    assign pos_y         = rec.py;
    assign pos_z         = rec.pz;
    assign corner_a      = rec.ca;
    assign corner_b      = rec.cb;
    assign corner_c      = rec.cc;
    assign last_record   = rec.last;

    assert property (@(posedge clk) disable iff (!rst_n) dcount != 9'd0)
        else $error("zero division count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && record_kind) |-> pos_x == 32'd0)
        else $error("triangle carries position");
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !record_kind) |-> corner_a == 10'd0)
        else $error("vertex carries corner");

endmodule
`default_nettype wire

[rtl/cmt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts a slice index, drops indexes above the count and
// queues the rest in a two-entry request queue.
module cmt_front #(
    parameter int MAX_DIVISIONS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [8:0]        division_index,
    input  wire logic [8:0]        div_count,
    output cmt_pkg::slice_req_t    req,
    output logic                   req_valid,
    input  wire logic              req_take
);
    cmt_pkg::slice_req_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    cmt_pkg::slice_req_t incoming;
    logic push, keep;

    // Classify the incoming index.
    always_comb
    begin
        incoming.index     = division_index;
        incoming.emit_rim  = ({1'b0, division_index} <= {1'b0, div_count});
        incoming.emit_tris = (division_index < div_count);
        incoming.emit_caps = (division_index == 9'd0);
    end

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign keep      = incoming.emit_rim;
    assign req       = q_reg[0];
    assign req_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_take) cnt_next = cnt_next - 2'd1;
        if (push && keep) cnt_next = cnt_next + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage, shifted on take.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            q_reg[0] <= q_reg[1];
            if (push && keep)
            begin
                if (cnt_reg == 2'd1) q_reg[0] <= incoming;
                else q_reg[1] <= incoming;
            end
        end
        else if (push && keep)
        begin
            if (cnt_reg == 2'd0) q_reg[0] <= incoming;
            else q_reg[1] <= incoming;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) req_take |-> req_valid)
        else $error("take from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) req_valid |-> req.emit_rim)
        else $error("dropped slice reached the queue");

endmodule
`default_nettype wire

[rtl/cmt_trig.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequential cos/sin unit: phase by restoring division, then Taylor
// polynomials through one shared multiplier, one product per cycle.
module cmt_trig #(
    parameter int PHASE_BITS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic [8:0]         index,
    input  wire logic [8:0]         div_count,
    output logic                    done,
    output logic signed [31:0]      cos_q30,
    output logic signed [31:0]      sin_q30
);
    localparam int NB = 9 + PHASE_BITS;
    localparam int QW = PHASE_BITS - 2;
    localparam int CW = $clog2(NB + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_X = 4'd2, S_X2 = 4'd3,
        S_T = 4'd4, S_S = 4'd5, S_C = 4'd6, S_OUT = 4'd7;

    logic [3:0] st_reg;
    logic [CW-1:0] cnt_reg;
    logic [NB-1:0] num_reg;
    logic [9:0] rem_reg;
    logic [8:0] den_reg;
    logic [1:0] quad_reg;
    logic swap_reg;
    logic [31:0] x_reg, x2_reg, t_reg, s_reg, c_reg;
    logic [2:0] k_reg;
    logic [63:0] prod;
    logic [31:0] ma, mb;
    logic [9:0] rtry;
    logic [NB-1:0] phase;
    logic [QW-1:0] r;
    logic [QW:0] rr;
    logic [31:0] term, divq;

    assign rtry = {rem_reg[8:0], num_reg[NB-1]};

    // Multiplier operand selection.
    always_comb
    begin
        ma = x2_reg;
        mb = t_reg;
        if (st_reg == S_X2) begin ma = x_reg; mb = x_reg; end
        if (st_reg == S_S) begin ma = x_reg; mb = t_reg; end
        if (st_reg == S_X) begin ma = PI_Q30_W; mb = {{(32-QW-1){1'b0}}, rr}; end
    end
    localparam logic [31:0] PI_Q30_W = cmt_pkg::PI_Q30;
    assign prod = {32'd0, ma} * {32'd0, mb};

    assign phase = num_reg;
    assign r     = phase[QW-1:0];
    assign rr    = ({1'b0, r} <= (1 << (QW - 1))) ? {1'b0, r}
                 : (({1'b1, {QW{1'b0}}}) - {1'b0, r});

    // Horner step: constant divisors per step.
    always_comb
    begin
        term = prod[61:30];
        if (k_reg == 3'd0) term = x2_reg;
        case (k_reg)
            3'd0: divq = term / 32'd42;
            3'd1: divq = term / 32'd20;
            3'd2: divq = term / 32'd6;
            3'd3: divq = x2_reg / 32'd56;
            3'd4: divq = term / 32'd30;
            3'd5: divq = term / 32'd12;
            default: divq = term / 32'd2;
        endcase
        if (k_reg == 3'd3) term = x2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done   <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        num_reg <= {index, {PHASE_BITS{1'b0}}} + NB'(div_count >> 1);
                        den_reg <= div_count;
                        rem_reg <= 10'd0;
                        cnt_reg <= CW'(NB);
                        st_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rtry >= {1'b0, den_reg})
                    begin
                        rem_reg <= rtry - {1'b0, den_reg};
                        num_reg <= {num_reg[NB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rtry;
                        num_reg <= {num_reg[NB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) st_reg <= S_X;
                end
                S_X:
                begin
                    quad_reg <= phase[PHASE_BITS-1:PHASE_BITS-2];
                    swap_reg <= !({1'b0, r} <= (1 << (QW - 1)));
                    x_reg    <= 32'((prod + (64'd1 << (PHASE_BITS - 2))) >> (PHASE_BITS - 1));
                    st_reg   <= S_X2;
                end
                S_X2:
                begin
                    x2_reg <= prod[61:30];
                    k_reg  <= 3'd0;
                    st_reg <= S_T;
                end
                S_T:
                begin
                    t_reg <= 32'h4000_0000 - divq;
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd2) st_reg <= S_S;
                    if (k_reg == 3'd6) begin c_reg <= 32'h4000_0000 - divq; st_reg <= S_OUT; end
                end
                S_S:
                begin
                    s_reg  <= prod[61:30];
                    st_reg <= S_T;
                end
                S_OUT:
                begin
                    done   <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Quadrant signs.
    logic signed [31:0] a, b;
    always_comb
    begin
        a = swap_reg ? s_reg : c_reg;
        b = swap_reg ? c_reg : s_reg;
        case (quad_reg)
            2'd0: begin cos_q30 = a;  sin_q30 = b;  end
            2'd1: begin cos_q30 = -b; sin_q30 = a;  end
            2'd2: begin cos_q30 = -a; sin_q30 = -b; end
            default: begin cos_q30 = b; sin_q30 = -a; end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(st_reg) == S_OUT)
        else $error("done outside output step");
    assert property (@(posedge clk) disable iff (!rst_n) (st_reg == S_DIV) |-> den_reg != 9'd0)
        else $error("zero divisor");

endmodule
`default_nettype wire

[rtl/cmt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back end: takes one slice request, computes the rim point and
// steps through its records one per cycle, strobe low on disabled ones.
module cmt_back #(
    parameter int PHASE_BITS = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cmt_pkg::slice_req_t    req,
    input  wire logic              req_valid,
    output logic                   req_take,
    input  wire logic [8:0]        div_count,
    input  wire logic [31:0]       cx,
    input  wire logic [31:0]       cy,
    input  wire logic [31:0]       cz,
    input  wire logic [30:0]       rad,
    input  wire logic [30:0]       hgt,
    input  wire logic              top_on,
    input  wire logic              bot_on,
    output logic                   strobe,
    output cmt_pkg::record_t       rec
);
    localparam logic [2:0] B_IDLE = 3'd0, B_TRIG = 3'd1, B_MX = 3'd2,
        B_MY = 3'd3, B_EMIT = 3'd4;

    logic [2:0] st_reg;
    cmt_pkg::slice_req_t cur_reg;
    logic [2:0] step_reg;
    logic trig_done;
    logic signed [31:0] cs, sn;
    logic [31:0] rx_reg, ry_reg, zt_reg, zb_reg;
    logic [31:0] mag;
    logic [61:0] p;
    logic signed [32:0] off, sum;
    logic [9:0] a, sv, bc;
    logic vld;
    logic lst;

    cmt_trig #(.PHASE_BITS(PHASE_BITS)) u_trig (
        .clk(clk), .rst_n(rst_n), .go(req_take), .index(req.index),
        .div_count(div_count), .done(trig_done), .cos_q30(cs), .sin_q30(sn)
    );

    assign req_take = (st_reg == B_IDLE) && req_valid;

    // One radius product per cycle, rounded to Q16.16.
    logic signed [31:0] tsel;
    assign tsel = (st_reg == B_MX) ? cs : sn;
    assign mag  = tsel[31] ? 32'(-tsel) : tsel;
    assign p    = {31'd0, rad} * {30'd0, mag};
    always_comb
    begin
        off = 33'({1'b0, 32'((p + 62'd536870912) >> 30)});
        if (tsel[31]) off = -off;
        sum = off + 33'($signed((st_reg == B_MX) ? cx : cy));
    end

    assign sv = {8'd0, top_on} + {8'd0, bot_on};
    assign bc = {9'd0, top_on};
    assign a  = sv + {cur_reg.index, 1'b0};

    // Record selection by step.
    always_comb
    begin
        rec = '0;
        vld = 1'b1;
        lst = 1'b0;
        case (step_reg)
            3'd0: begin vld = cur_reg.emit_caps && top_on; rec.pz = zt_reg;
                        rec.px = cx; rec.py = cy; end
            3'd1: begin vld = cur_reg.emit_caps && bot_on; rec.vnum = bc; rec.pz = zb_reg;
                        rec.px = cx; rec.py = cy; end
            3'd2: begin rec.vnum = a; rec.px = rx_reg; rec.py = ry_reg; rec.pz = zt_reg; end
            3'd3: begin rec.vnum = a + 10'd1; rec.px = rx_reg; rec.py = ry_reg;
                        rec.pz = zb_reg; lst = !cur_reg.emit_tris; end
            3'd4: begin vld = cur_reg.emit_tris; rec.kind = 1'b1; rec.ca = a;
                        rec.cb = a + 10'd1; rec.cc = a + 10'd2; end
            3'd5: begin vld = cur_reg.emit_tris; rec.kind = 1'b1; rec.ca = a + 10'd1;
                        rec.cb = a + 10'd3; rec.cc = a + 10'd2; lst = !top_on && !bot_on; end
            3'd6: begin vld = cur_reg.emit_tris && top_on; rec.kind = 1'b1; rec.ca = 10'd0;
                        rec.cb = a; rec.cc = a + 10'd2; lst = !bot_on; end
            default: begin vld = cur_reg.emit_tris && bot_on; rec.kind = 1'b1; rec.ca = bc;
                        rec.cb = a + 10'd3; rec.cc = a + 10'd1; lst = 1'b1; end
        endcase
        rec.last = lst;
    end
    assign strobe = (st_reg == B_EMIT) && vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
        end
        else
        begin
            unique case (st_reg)
                B_IDLE: if (req_valid) st_reg <= B_TRIG;
                B_TRIG: if (trig_done) st_reg <= B_MX;
                B_MX:   st_reg <= B_MY;
                B_MY:   st_reg <= B_EMIT;
                B_EMIT: if (lst || step_reg == 3'd7) st_reg <= B_IDLE;
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cur_reg <= req;
            zt_reg  <= cmt_pkg::sat33($signed({cz[31], cz}) + $signed({3'd0, hgt[30:1]}));
            zb_reg  <= cmt_pkg::sat33($signed({cz[31], cz}) - $signed({3'd0, hgt[30:1]}));
        end
        if (st_reg == B_MX) rx_reg <= cmt_pkg::sat33(sum);
        if (st_reg == B_MY)
        begin
            ry_reg   <= cmt_pkg::sat33(sum);
            step_reg <= 3'd0;
        end
        if (st_reg == B_EMIT) step_reg <= step_reg + 3'd1;
    end

    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> st_reg == B_EMIT)
        else $error("strobe outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && rec.last) |=> st_reg == B_IDLE)
        else $error("emit continued past last record");
    assert property (@(posedge clk) disable iff (!rst_n) req_take |-> req_valid)
        else $error("take without request");

endmodule
`default_nettype wire

[tb/cylinder_mesh_tessellator_test.sv]
`timescale 1ns / 1ps
module cylinder_mesh_tessellator_test;
    import cmt_pkg::*;

    localparam int MAX_DIV   = 256;
    localparam int PH_BITS   = 10;
    localparam int DRAIN     = 80;
    localparam int WD_LIMIT  = 5000;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned PI_FIX  = 64'd3373259426;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_RADIUS,
        REG_HEIGHT, REG_TOP_CAP, REG_BOTTOM_CAP, REG_DIVISIONS
    } cfg_reg_e;

    // Mesh predictor and store of the records still to come.
    class mesh_scoreboard;
        logic signed [31:0] cen_x, cen_y, cen_z;
        logic [30:0] rad, hgt;
        logic top_on, bot_on;
        logic [8:0] div_raw;
        record_t pending_records[$];
        int errors;

        function new();
            cen_x = 0; cen_y = 0; cen_z = 0;
            rad = 31'd32768; hgt = 31'd65536;
            top_on = 1; bot_on = 1; div_raw = 9'd16;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_e idx, logic [31:0] v);
            case (idx)
                REG_CENTER_X:   cen_x = v;
                REG_CENTER_Y:   cen_y = v;
                REG_CENTER_Z:   cen_z = v;
                REG_RADIUS:     rad = v[30:0];
                REG_HEIGHT:     hgt = v[30:0];
                REG_TOP_CAP:    top_on = v[0];
                REG_BOTTOM_CAP: bot_on = v[0];
                default:        div_raw = v[8:0];
            endcase
        endfunction

        function int slice_count();
            int d;
            d = div_raw;
            if (d < 1) d = 1;
            if (d > MAX_DIV) d = MAX_DIV;
            return d;
        endfunction

        // Truncated Taylor sine and cosine in Q30 for angles up to pi/4.
        function void taylor(longint unsigned x, output longint unsigned s,
                             output longint unsigned c);
            longint unsigned x2, t;
            x2 = (x * x) >> 30;
            t = ONE_Q30 - x2 / 42;
            t = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s = (x * t) >> 30;
            t = ONE_Q30 - x2 / 56;
            t = ONE_Q30 - ((x2 * t) >> 30) / 30;
            t = ONE_Q30 - ((x2 * t) >> 30) / 12;
            c = ONE_Q30 - ((x2 * t) >> 30) / 2;
        endfunction

        function void phase_cos_sin(longint unsigned p, output longint cs,
                                    output longint sn);
            longint unsigned quarter, q, r, x, s, c;
            quarter = 64'd1 << (PH_BITS - 2);
            q = (p >> (PH_BITS - 2)) & 3;
            r = p & (quarter - 1);
            if (r * 2 <= quarter) begin
                x = (r * PI_FIX + (64'd1 << (PH_BITS - 2))) >> (PH_BITS - 1);
                taylor(x, s, c);
            end
            else begin
                x = ((quarter - r) * PI_FIX + (64'd1 << (PH_BITS - 2))) >> (PH_BITS - 1);
                taylor(x, c, s);
            end
            case (q)
                0: begin cs = c; sn = s; end
                1: begin cs = -longint'(s); sn = c; end
                2: begin cs = -longint'(c); sn = -longint'(s); end
                default: begin cs = s; sn = -longint'(c); end
            endcase
        endfunction

        function longint rim_offset(longint t);
            longint unsigned mag;
            longint v;
            mag = (t < 0) ? longint'(-t) : t;
            v = ((longint'(rad) * mag) + (64'd1 << 29)) >> 30;
            return (t < 0) ? -v : v;
        endfunction

        function logic [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function void push_vertex(int num, longint x, longint y, longint z);
            record_t r;
            r = '0;
            r.vnum = num[9:0];
            r.px = clamp32(x);
            r.py = clamp32(y);
            r.pz = clamp32(z);
            pending_records.push_back(r);
        endfunction

        function void push_tri(int a, int b, int c);
            record_t r;
            r = '0;
            r.kind = 1'b1;
            r.ca = a[9:0];
            r.cb = b[9:0];
            r.cc = c[9:0];
            pending_records.push_back(r);
        endfunction

        // Work out the records that one accepted slice request causes.
        function void note_request(int ui);
            int d, first, bc, a;
            longint ztop, zbot, cs, sn;
            longint unsigned p;
            d = slice_count();
            if (ui > d) return;
            ztop = longint'(cen_z) + longint'(hgt >> 1);
            zbot = longint'(cen_z) - longint'(hgt >> 1);
            first = top_on + bot_on;
            bc = top_on ? 1 : 0;
            if (ui == 0) begin
                if (top_on) push_vertex(0, cen_x, cen_y, ztop);
                if (bot_on) push_vertex(bc, cen_x, cen_y, zbot);
            end
            p = ((longint'(ui) << PH_BITS) + d / 2) / d;
            p = p & ((64'd1 << PH_BITS) - 1);
            phase_cos_sin(p, cs, sn);
            a = first + 2 * ui;
            push_vertex(a, longint'(cen_x) + rim_offset(cs),
                        longint'(cen_y) + rim_offset(sn), ztop);
            push_vertex(a + 1, longint'(cen_x) + rim_offset(cs),
                        longint'(cen_y) + rim_offset(sn), zbot);
            if (ui < d) begin
                push_tri(a, a + 1, a + 2);
                push_tri(a + 1, a + 3, a + 2);
                if (top_on) push_tri(0, a, a + 2);
                if (bot_on) push_tri(bc, a + 3, a + 1);
            end
            pending_records[$].last = 1'b1;
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_record(record_t got);
            record_t e;
            if (pending_records.size() == 0) begin
                $error("record with nothing expected: kind %0d", got.kind);
                errors++;
                return;
            end
            e = pending_records.pop_front();
            cmp("record_kind", e.kind, got.kind);
            cmp("vertex_number", e.vnum, got.vnum);
            cmp("pos_x", e.px, got.px);
            cmp("pos_y", e.py, got.py);
            cmp("pos_z", e.pz, got.pz);
            cmp("corner_a", e.ca, got.ca);
            cmp("corner_b", e.cb, got.cb);
            cmp("corner_c", e.cc, got.cc);
            cmp("last_record", e.last, got.last);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [8:0] division_index = '0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic strobe, record_kind, last_record;
    logic [9:0] vertex_number, corner_a, corner_b, corner_c;
    logic [31:0] pos_x, pos_y, pos_z;

    mesh_scoreboard sb = new();
    int idle_cycles = 0;

    always #6 clk = ~clk;

    cylinder_mesh_tessellator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .division_index(division_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .strobe(strobe), .record_kind(record_kind),
        .vertex_number(vertex_number), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .last_record(last_record)
    );

    // Record monitor and watchdog.
    always @(posedge clk) begin
        record_t r;
        if (rst_n) begin
            if (strobe) begin
                r.kind = record_kind; r.vnum = vertex_number;
                r.px = pos_x; r.py = pos_y; r.pz = pos_z;
                r.ca = corner_a; r.cb = corner_b; r.cc = corner_c;
                r.last = last_record;
                sb.check_record(r);
            end
            if (strobe || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Send one slice request, optionally after an idle gap.
    task automatic send_slice(int ui, int gap);
        if (gap > 0) begin
            start = 0;
            repeat (gap) @(negedge clk);
        end
        start = 1;
        division_index = ui[8:0];
        do @(posedge clk); while (busy);
        sb.note_request(ui);
        @(negedge clk);
    endtask

    // Let the block drain fully before touching configuration.
    task automatic settle();
        start = 0;
        @(negedge clk);
        while (sb.pending_records.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic random_config();
        logic [31:0] v;
        v = $urandom;
        write_reg(REG_CENTER_X, ($urandom_range(0, 7) == 0) ? v : {{12{v[19]}}, v[19:0]});
        v = $urandom;
        write_reg(REG_CENTER_Y, ($urandom_range(0, 7) == 0) ? v : {{12{v[19]}}, v[19:0]});
        v = $urandom;
        write_reg(REG_CENTER_Z, ($urandom_range(0, 7) == 0) ? v : {{12{v[19]}}, v[19:0]});
        write_reg(REG_RADIUS, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1 << 22));
        write_reg(REG_HEIGHT, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1 << 22));
        write_reg(REG_TOP_CAP, $urandom);
        write_reg(REG_BOTTOM_CAP, $urandom);
        write_reg(REG_DIVISIONS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                             : $urandom_range(1, 24));
    endtask

    // Random slices; indexes above the count are ignored and not counted.
    task automatic random_slices(int n, bit with_gaps);
        int d, ui, sel, done;
        done = 0;
        while (done < n) begin
            d = sb.slice_count();
            sel = $urandom_range(0, 19);
            if (sel == 0 && d < 511) ui = $urandom_range(d + 1, 511);
            else if (sel == 1) ui = d;
            else if (sel == 2) ui = 0;
            else ui = $urandom_range(0, d);
            if (ui <= d) done++;
            send_slice(ui, (with_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0);
        end
    endtask

    initial begin
        int k;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: reset settings, first, last and out-of-range indexes.
        send_slice(0, 0);
        send_slice(1, 0);
        send_slice(15, 3);
        send_slice(16, 0);
        send_slice(17, 0);
        send_slice(511, 0);
        send_slice(4, 0);
        settle();

        // Saturating corners, top cap off, single slice.
        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_CENTER_Z, 32'h7FFF_FFFF);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        write_reg(REG_HEIGHT, 32'h7FFF_FFFF);
        write_reg(REG_TOP_CAP, 0);
        write_reg(REG_BOTTOM_CAP, 1);
        write_reg(REG_DIVISIONS, 1);
        send_slice(0, 0);
        send_slice(1, 0);
        send_slice(2, 0);
        settle();

        // Division count of zero, and the other extremes.
        write_reg(REG_CENTER_X, 32'h8000_0000);
        write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Z, 32'h8000_0000);
        write_reg(REG_RADIUS, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_TOP_CAP, 1);
        write_reg(REG_BOTTOM_CAP, 0);
        write_reg(REG_DIVISIONS, 0);
        send_slice(0, 0);
        send_slice(1, 0);
        settle();

        // Maximum and over-range division counts.
        write_reg(REG_CENTER_X, 0);
        write_reg(REG_CENTER_Y, 0);
        write_reg(REG_CENTER_Z, 0);
        write_reg(REG_RADIUS, 32'h0001_0000);
        write_reg(REG_HEIGHT, 32'h0002_0000);
        write_reg(REG_TOP_CAP, 1);
        write_reg(REG_BOTTOM_CAP, 1);
        write_reg(REG_DIVISIONS, 256);
        send_slice(255, 0);
        send_slice(256, 0);
        send_slice(64, 0);
        send_slice(128, 0);
        settle();
        write_reg(REG_DIVISIONS, 511);
        send_slice(256, 0);
        send_slice(257, 0);
        send_slice(192, 0);
        settle();

        // Random phases, each with its own settings.
        for (k = 0; k < 7; k++) begin
            random_config();
            random_slices(60, 1'b1);
            settle();
        end

        // Closing stretch without gaps.
        random_config();
        random_slices(60, 1'b0);
        settle();

        if (sb.errors == 0 && sb.pending_records.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

[files.f]
rtl/cmt_pkg.sv
rtl/cmt_front.sv
rtl/cmt_trig.sv
rtl/cmt_back.sv
rtl/cylinder_mesh_tessellator.sv
tb/cylinder_mesh_tessellator_test.sv
